### rtl/dlle_pkg.sv
// Shared codes and types for the doubly linked list engine.
// No dependencies; imported by doubly_linked_list_engine and tb_top.
`default_nettype none

package dlle_pkg;

	// Operation codes carried on the input tuser
	localparam logic [2:0] MODE_INS_HEAD = 3'd0;
	localparam logic [2:0] MODE_INS_TAIL = 3'd1;
	localparam logic [2:0] MODE_DELETE   = 3'd2;
	localparam logic [2:0] MODE_TRV_FWD  = 3'd3;
	localparam logic [2:0] MODE_TRV_BWD  = 3'd4;

	// Result status codes carried on the output tuser
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	localparam int DATA_W = 32;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_SCAN     = 9'b000000010,
		ST_INS_NODE = 9'b000000100,
		ST_INS_LINK = 9'b000001000,
		ST_WALK_RD  = 9'b000010000,
		ST_DEL_CHK  = 9'b000100000,
		ST_DEL_UNLK = 9'b001000000,
		ST_TRV_EMIT = 9'b010000000,
		ST_RESP     = 9'b100000000
	} state_t;

endpackage

`default_nettype wire

### rtl/dlle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the node data and link stores of the list engine.
`default_nettype none

module dlle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/doubly_linked_list_engine.sv
// Top level of the doubly linked list engine: sequencer, pointers, slot map.
// Depends on dlle_pkg and on dlle_ram for the data, next and prev stores.
//
//  channel  | dir | tdata            | tuser          | tlast
//  ---------+-----+------------------+----------------+---------------
//  s_axis   | in  | value[31:0]      | mode[2:0]      | -
//  m_axis   | out | data[31:0]       | status[1:0]    | last
//
// Insert scans the slot map for the lowest free slot, one slot a cycle; delete
// walks from the head until the value matches or the entry count runs out;
// traversal walks the link stores one node a cycle while the output takes
// every beat.
// Reset clears the slot map, head, tail and count; node stores are not cleared.
// A stalled m_axis holds the walk in place; s_axis_tready is high only between
// operations, while the output register decouples the last result.
`default_nettype none

module doubly_linked_list_engine
	import dlle_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [31:0] value
	input  wire  [2:0]  s_axis_tuser,   // [2:0] mode
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] data
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast
);

	// Index width covers the null index, which equals CAPACITY
	localparam int IW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);

	state_t              state_q;
	logic [2:0]          mode_q;
	logic [DATA_W-1:0]   value_q;
	logic [1:0]          status_q;
	logic [CAPACITY-1:0] slot_used_q;
	logic [IW-1:0]       head_q, tail_q, count_q;
	logic [IW-1:0]       cur_q, steps_q;
	logic [AW-1:0]       scan_q;
	logic [IW-1:0]       p_q, n_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [1:0]        out_status_q;
	logic              out_last_q;

	// RAM ports
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] data_rd;
	logic [IW-1:0]     next_rd, prev_rd;
	logic              next_we, prev_we;
	logic [AW-1:0]     next_waddr, prev_waddr;
	logic [IW-1:0]     next_wdata, prev_wdata;

	logic          out_free, load_out, load_last;
	logic [DATA_W-1:0] load_data;
	logic          first_node, at_head, fwd;
	logic [IW-1:0] slot_idx, trv_nxt, steps_inc;
	logic          trv_fin;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	assign out_free   = !out_valid_q || m_axis_tready;
	assign first_node = (head_q >= NULL_IDX) || (tail_q >= NULL_IDX) || (count_q == '0);
	assign at_head    = (mode_q == MODE_INS_HEAD);
	assign fwd        = (mode_q == MODE_TRV_FWD);
	assign slot_idx   = IW'(scan_q);
	assign steps_inc  = steps_q + 1'b1;
	assign trv_nxt    = fwd ? next_rd : prev_rd;
	assign trv_fin    = (trv_nxt >= NULL_IDX) || (steps_inc >= count_q);

	dlle_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
		.clk  (clk),
		.we   (state_q == ST_INS_NODE),
		.waddr(scan_q),
		.wdata(value_q),
		.raddr(raddr),
		.rdata(data_rd)
	);

	dlle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
		.clk  (clk),
		.we   (next_we),
		.waddr(next_waddr),
		.wdata(next_wdata),
		.raddr(raddr),
		.rdata(next_rd)
	);

	dlle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
		.clk  (clk),
		.we   (prev_we),
		.waddr(prev_waddr),
		.wdata(prev_wdata),
		.raddr(raddr),
		.rdata(prev_rd)
	);

	// Read address: follow the link straight out of the RAM while walking,
	// otherwise hold the current node so its data stays on the read port.
	always_comb begin
		raddr = cur_q[AW-1:0];
		case (state_q)
			ST_DEL_CHK: begin
				raddr = next_rd[AW-1:0];
			end
			ST_TRV_EMIT: begin
				if (out_free) begin
					raddr = trv_nxt[AW-1:0];
				end
			end
			default: begin
				raddr = cur_q[AW-1:0];
			end
		endcase
	end

	// Link store writes
	always_comb begin
		next_we    = 1'b0;
		next_waddr = scan_q;
		next_wdata = NULL_IDX;
		prev_we    = 1'b0;
		prev_waddr = scan_q;
		prev_wdata = NULL_IDX;
		case (state_q)
			ST_INS_NODE: begin
				next_we    = 1'b1;
				next_wdata = (at_head && !first_node) ? head_q : NULL_IDX;
				prev_we    = 1'b1;
				prev_wdata = (!at_head && !first_node) ? tail_q : NULL_IDX;
			end
			ST_INS_LINK: begin
				// hook the old end of the list to the new node
				next_we    = !first_node && !at_head;
				next_waddr = tail_q[AW-1:0];
				next_wdata = slot_idx;
				prev_we    = !first_node && at_head;
				prev_waddr = head_q[AW-1:0];
				prev_wdata = slot_idx;
			end
			ST_DEL_UNLK: begin
				next_we    = (p_q < NULL_IDX);
				next_waddr = p_q[AW-1:0];
				next_wdata = n_q;
				prev_we    = (n_q < NULL_IDX);
				prev_waddr = n_q[AW-1:0];
				prev_wdata = p_q;
			end
			default: begin
				next_we = 1'b0;
				prev_we = 1'b0;
			end
		endcase
	end

	// Output register load
	always_comb begin
		load_out  = 1'b0;
		load_data = '0;
		load_last = 1'b1;
		case (state_q)
			ST_RESP: begin
				load_out = out_free;
			end
			ST_TRV_EMIT: begin
				load_out  = out_free;
				load_data = data_rd;
				load_last = trv_fin;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q   <= load_data;
			out_status_q <= (state_q == ST_TRV_EMIT) ? STAT_OK : status_q;
			out_last_q   <= load_last;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_used_q <= '0;
			head_q      <= NULL_IDX;
			tail_q      <= NULL_IDX;
			count_q     <= '0;
			mode_q      <= MODE_INS_HEAD;
			value_q     <= '0;
			status_q    <= STAT_OK;
			cur_q       <= '0;
			steps_q     <= '0;
			scan_q      <= '0;
			p_q         <= '0;
			n_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						mode_q  <= s_axis_tuser;
						value_q <= s_axis_tdata;
						steps_q <= '0;
						scan_q  <= '0;
						case (s_axis_tuser)
							MODE_INS_HEAD, MODE_INS_TAIL: begin
								if (count_q >= NULL_IDX) begin
									status_q <= STAT_FULL;
									state_q  <= ST_RESP;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							MODE_DELETE: begin
								if (count_q == '0 || head_q >= NULL_IDX) begin
									status_q <= STAT_EMPTY;
									state_q  <= ST_RESP;
								end else begin
									cur_q   <= head_q;
									state_q <= ST_WALK_RD;
								end
							end
							MODE_TRV_FWD: begin
								if (count_q == '0 || head_q >= NULL_IDX) begin
									status_q <= STAT_EMPTY;
									state_q  <= ST_RESP;
								end else begin
									cur_q   <= head_q;
									state_q <= ST_WALK_RD;
								end
							end
							MODE_TRV_BWD: begin
								if (count_q == '0 || tail_q >= NULL_IDX) begin
									status_q <= STAT_EMPTY;
									state_q  <= ST_RESP;
								end else begin
									cur_q   <= tail_q;
									state_q <= ST_WALK_RD;
								end
							end
							default: begin
								// unused codes: acknowledge and drop
								status_q <= STAT_OK;
								state_q  <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// a free slot exists whenever the pool is not full
					if (!slot_used_q[scan_q]) begin
						state_q <= ST_INS_NODE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_INS_NODE: begin
					state_q <= ST_INS_LINK;
				end
				ST_INS_LINK: begin
					slot_used_q[scan_q] <= 1'b1;
					count_q <= count_q + 1'b1;
					if (first_node) begin
						head_q <= slot_idx;
						tail_q <= slot_idx;
					end else if (at_head) begin
						head_q <= slot_idx;
					end else begin
						tail_q <= slot_idx;
					end
					status_q <= STAT_OK;
					state_q  <= ST_RESP;
				end
				ST_WALK_RD: begin
					state_q <= (mode_q == MODE_DELETE) ? ST_DEL_CHK : ST_TRV_EMIT;
				end
				ST_DEL_CHK: begin
					if (cur_q >= NULL_IDX || steps_q >= count_q) begin
						status_q <= STAT_NOTFOUND;
						state_q  <= ST_RESP;
					end else if (data_rd == value_q) begin
						p_q     <= prev_rd;
						n_q     <= next_rd;
						state_q <= ST_DEL_UNLK;
					end else begin
						cur_q   <= next_rd;
						steps_q <= steps_inc;
					end
				end
				ST_DEL_UNLK: begin
					if (p_q >= NULL_IDX) begin
						head_q <= n_q;
					end
					if (n_q >= NULL_IDX) begin
						tail_q <= p_q;
					end
					if (count_q == IW'(1)) begin
						head_q <= NULL_IDX;
						tail_q <= NULL_IDX;
					end
					slot_used_q[cur_q[AW-1:0]] <= 1'b0;
					count_q  <= count_q - 1'b1;
					status_q <= STAT_OK;
					state_q  <= ST_RESP;
				end
				ST_TRV_EMIT: begin
					// advance only when the output register takes the beat
					if (out_free) begin
						cur_q   <= trv_nxt;
						steps_q <= steps_inc;
						if (trv_fin) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for doubly_linked_list_engine: predicts every result beat
// of the list operations and compares them on the master stream. Uses dlle_pkg.
`timescale 1ns / 1ps

module tb_top;
	import dlle_pkg::*;

	localparam int LIST_CAP    = 16;
	localparam int IDX_W       = $clog2(LIST_CAP + 1);
	localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(LIST_CAP);
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 64;
	localparam int QUIET_TAIL  = 40;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] value;
	} list_op_t;

	typedef struct packed {
		logic [31:0] data;
		logic [1:0]  status;
		logic        last;
	} result_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] value
	logic [2:0]  s_axis_tuser = '0;   // [2:0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] data
	logic [1:0]  m_axis_tuser;        // [1:0] status
	logic        m_axis_tlast;

	doubly_linked_list_engine #(
		.CAPACITY(LIST_CAP)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the node pool, kept in step with accepted operations
	logic [31:0]      pool_data [LIST_CAP];
	logic [IDX_W-1:0] pool_next [LIST_CAP];
	logic [IDX_W-1:0] pool_prev [LIST_CAP];
	bit               pool_used [LIST_CAP];
	logic [IDX_W-1:0] list_head = NULL_IDX;
	logic [IDX_W-1:0] list_tail = NULL_IDX;
	int               list_len = 0;

	list_op_t     cmd_queue[$];
	result_beat_t want_beats[$];

	int ops_total = 0;
	int ops_taken = 0;
	int beats_checked = 0;
	int error_count = 0;
	int cycle_count = 0;
	int quiet_mark = 0;
	int deepest = 0;
	int full_seen = 0;
	int empty_seen = 0;
	int miss_seen = 0;
	int src_gap = 0;
	int sink_gap = 0;
	bit quiet;
	list_op_t cur_op;

	assign quiet = (ops_taken >= quiet_mark);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] MISMATCH beat %0d: %s got 0x%08h want 0x%08h",
			$time, beats_checked, what, got, want);
		error_count++;
	endtask

	// Run one operation on the shadow list and queue the beats it must produce
	task automatic list_apply(input list_op_t op);
		int slot;
		int cur;
		int steps;
		int k;
		int nxt;
		int p;
		int n;
		bit fwd;
		result_beat_t b;
		b = '{data: '0, status: STAT_OK, last: 1'b1};
		case (op.mode)
			MODE_INS_HEAD, MODE_INS_TAIL: begin
				slot = -1;
				for (int i = LIST_CAP - 1; i >= 0; i--)
					if (!pool_used[i])
						slot = i;
				if (slot < 0 || list_len >= LIST_CAP) begin
					b.status = STAT_FULL;
					full_seen++;
				end else begin
					pool_data[slot] = op.value;
					pool_used[slot] = 1'b1;
					if (list_head >= LIST_CAP || list_tail >= LIST_CAP || list_len == 0) begin
						pool_next[slot] = NULL_IDX;
						pool_prev[slot] = NULL_IDX;
						list_head = IDX_W'(slot);
						list_tail = IDX_W'(slot);
					end else if (op.mode == MODE_INS_HEAD) begin
						pool_next[slot] = list_head;
						pool_prev[slot] = NULL_IDX;
						pool_prev[list_head] = IDX_W'(slot);
						list_head = IDX_W'(slot);
					end else begin
						pool_next[slot] = NULL_IDX;
						pool_prev[slot] = list_tail;
						pool_next[list_tail] = IDX_W'(slot);
						list_tail = IDX_W'(slot);
					end
					list_len++;
					if (list_len > deepest)
						deepest = list_len;
				end
				want_beats.push_back(b);
			end
			MODE_DELETE: begin
				if (list_len == 0 || list_head >= LIST_CAP) begin
					b.status = STAT_EMPTY;
					empty_seen++;
				end else begin
					// Search from the head, bounded by the entry count
					cur = list_head;
					steps = 0;
					while (cur < LIST_CAP && steps < list_len && pool_data[cur] != op.value) begin
						cur = pool_next[cur];
						steps++;
					end
					if (cur >= LIST_CAP || steps >= list_len) begin
						b.status = STAT_NOTFOUND;
						miss_seen++;
					end else begin
						p = pool_prev[cur];
						n = pool_next[cur];
						if (p < LIST_CAP)
							pool_next[p] = IDX_W'(n);
						else
							list_head = IDX_W'(n);
						if (n < LIST_CAP)
							pool_prev[n] = IDX_W'(p);
						else
							list_tail = IDX_W'(p);
						pool_used[cur] = 1'b0;
						list_len--;
						if (list_len == 0) begin
							list_head = NULL_IDX;
							list_tail = NULL_IDX;
						end
					end
				end
				want_beats.push_back(b);
			end
			MODE_TRV_FWD, MODE_TRV_BWD: begin
				fwd = (op.mode == MODE_TRV_FWD);
				cur = fwd ? list_head : list_tail;
				if (list_len == 0 || cur >= LIST_CAP) begin
					b.status = STAT_EMPTY;
					empty_seen++;
					want_beats.push_back(b);
				end else begin
					k = 0;
					while (cur < LIST_CAP && k < list_len) begin
						nxt = fwd ? pool_next[cur] : pool_prev[cur];
						b.data = pool_data[cur];
						b.last = (nxt >= LIST_CAP) || (k + 1 >= list_len);
						want_beats.push_back(b);
						k++;
						cur = nxt;
					end
				end
			end
			default: want_beats.push_back(b);  // unused modes: plain acknowledge
		endcase
	endtask

	// Source side: present queued operations, predict each one as its beat is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				list_apply(cur_op);
				ops_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					cur_op = cmd_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= cur_op.value;
					s_axis_tuser  <= cur_op.mode;
					if (!quiet && $urandom_range(0, 4) == 0)
						src_gap = $urandom_range(1, 10);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: random stall bursts, and check every beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (want_beats.size() == 0) begin
					report_mismatch("unexpected beat, data", m_axis_tdata, 32'h0);
				end else begin
					result_beat_t w;
					w = want_beats.pop_front();
					if (m_axis_tdata !== w.data)
						report_mismatch("data", m_axis_tdata, w.data);
					if (m_axis_tuser !== w.status)
						report_mismatch("status", 32'(m_axis_tuser), 32'(w.status));
					if (m_axis_tlast !== w.last)
						report_mismatch("last", 32'(m_axis_tlast), 32'(w.last));
				end
				beats_checked++;
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 10);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected",
				cycle_count, want_beats.size());
			$display("doubly_linked_list_engine test failed");
			$finish;
		end
	end

	// Value mix: extremes, a small set that repeats so deletes hit duplicates, and noise
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3, 4: return 32'($urandom_range(0, 7)) - 32'd3;
			default: return $urandom();
		endcase
	endfunction

	task automatic add_op(input logic [2:0] mode, input logic [31:0] value);
		list_op_t op;
		op.mode  = mode;
		op.value = value;
		cmd_queue.push_back(op);
		ops_total++;
	endtask

	initial begin
		logic [31:0] stored[$];
		logic [31:0] v;
		int n;
		int j;

		// Directed: empty list, both ends, extremes, duplicates, every delete position
		add_op(MODE_TRV_FWD, 32'hdead_beef);
		add_op(MODE_TRV_BWD, 32'h0);
		add_op(MODE_DELETE, 32'd5);
		add_op(MODE_INS_TAIL, 32'h7fff_ffff);
		add_op(MODE_INS_HEAD, 32'h8000_0000);
		add_op(MODE_INS_TAIL, 32'h0);
		add_op(MODE_INS_HEAD, 32'hffff_ffff);
		add_op(MODE_INS_TAIL, 32'h0);
		add_op(MODE_TRV_FWD, 32'h0);
		add_op(MODE_TRV_BWD, 32'hffff_ffff);
		add_op(MODE_DELETE, 32'd12345);
		add_op(MODE_DELETE, 32'h0);          // first of two equal values, mid list
		add_op(MODE_DELETE, 32'hffff_ffff);  // head
		add_op(MODE_DELETE, 32'h0);          // tail
		add_op(MODE_TRV_FWD, 32'h0);
		add_op(3'd5, 32'h1);
		add_op(3'd6, 32'hffff_ffff);
		add_op(3'd7, 32'h8000_0000);
		add_op(MODE_DELETE, 32'h8000_0000);
		add_op(MODE_DELETE, 32'h7fff_ffff);  // last entry, list empties
		add_op(MODE_TRV_BWD, 32'h0);

		// Random: episodes of fills, drains and mixed traffic; start by filling to capacity or beyond
		j = 0;
		while (ops_total < 250) begin
			case ((j == 0) ? 0 : $urandom_range(0, 9))
				0, 1, 2: begin
					if (j == 0 || $urandom_range(0, 1) == 0)
						n = LIST_CAP - stored.size() + $urandom_range(0, 3);
					else
						n = $urandom_range(2, 6);
					repeat (n) begin
						v = pick_value();
						add_op($urandom_range(0, 1) ? MODE_INS_HEAD : MODE_INS_TAIL, v);
						if (stored.size() < LIST_CAP)
							stored.push_back(v);
					end
					add_op($urandom_range(0, 1) ? MODE_TRV_FWD : MODE_TRV_BWD, $urandom());
				end
				3, 4, 5: begin
					n = $urandom_range(2, 10);
					repeat (n) begin
						if (stored.size() > 0 && $urandom_range(0, 5) != 0) begin
							int k;
							k = $urandom_range(0, stored.size() - 1);
							add_op(MODE_DELETE, stored[k]);
							stored.delete(k);
						end else begin
							add_op(MODE_DELETE, pick_value());
						end
					end
					add_op($urandom_range(0, 1) ? MODE_TRV_FWD : MODE_TRV_BWD, $urandom());
				end
				6, 7: begin
					repeat ($urandom_range(3, 8)) begin
						v = pick_value();
						case ($urandom_range(0, 4))
							0: begin
								add_op(MODE_INS_HEAD, v);
								if (stored.size() < LIST_CAP)
									stored.push_back(v);
							end
							1: begin
								add_op(MODE_INS_TAIL, v);
								if (stored.size() < LIST_CAP)
									stored.push_back(v);
							end
							2: add_op(MODE_DELETE,
								(stored.size() > 0) ? stored[$urandom_range(0, stored.size() - 1)] : v);
							3: add_op(MODE_TRV_FWD, v);
							default: add_op(MODE_TRV_BWD, v);
						endcase
					end
				end
				8: begin
					add_op(MODE_TRV_FWD, $urandom());
					add_op(MODE_TRV_BWD, $urandom());
				end
				default: begin
					add_op(3'($urandom_range(5, 7)), $urandom());
					add_op(MODE_DELETE, $urandom());
				end
			endcase
			j++;
		end
		quiet_mark = ops_total - QUIET_TAIL;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_taken < ops_total)
			@(posedge clk);
		while (want_beats.size() != 0)
			@(posedge clk);
		// Give the block time to show any stray beat
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d list operations, checked %0d result beats, deepest list %0d entries.",
			ops_taken, beats_checked, deepest);
		$display("Pool full %0d times, empty %0d times, value missing %0d times; %0d mismatches.",
			full_seen, empty_seen, miss_seen, error_count);
		if (error_count == 0 && want_beats.size() == 0) begin
			$display("doubly_linked_list_engine test passed");
		end else begin
			$display("doubly_linked_list_engine test failed");
		end
		$finish;
	end

endmodule
